>>> rtl/irs_pkg.sv
// ----------------------------------------------------------------------------
// irs_pkg
// Shared types and constants of the image scaler: register indexes, field
// widths and the word that travels down the pipeline.
// ----------------------------------------------------------------------------
package irs_pkg;

  localparam int CoordW = 7;
  localparam int ChanW  = 8;
  localparam int PixW   = 4 * ChanW;
  localparam int CfgW   = 8;
  localparam int CfgIdxW = 3;
  localparam int FracW  = 8;
  localparam int AccW   = 24;

  localparam logic [CfgIdxW-1:0] CfgSrcWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSrcHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDstWidth  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDstHeight = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFilter    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgChannels  = 3'd5;

  localparam logic FilterNearest  = 1'b0;
  localparam logic FilterBilinear = 1'b1;

  localparam logic ActStore   = 1'b0;
  localparam logic ActCompute = 1'b1;

  typedef struct packed {
    logic              store;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [PixW-1:0]   pix;
  } item_t;

endpackage

>>> rtl/irs_ram.sv
// ----------------------------------------------------------------------------
// irs_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module irs_ram #(
  parameter int Width = 32,
  parameter int Depth = 4,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/irs_coord.sv
// ----------------------------------------------------------------------------
// irs_coord
// One axis lane: maps a destination coordinate to the low and high source
// indexes and the Q0.8 fraction, through a pipelined restoring divider.
// ----------------------------------------------------------------------------
module irs_coord #(
  parameter int MAX_DIM = 128,
  localparam int DimW = $clog2(MAX_DIM + 1),
  localparam int IdxW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1,
  localparam int NumW = irs_pkg::CoordW + DimW + 8
) (
  input  logic                       clk_i,
  input  logic [NumW:0]              en_i,
  input  logic [irs_pkg::CoordW-1:0] d_i,
  input  logic [DimW-1:0]            src_i,
  input  logic [DimW-1:0]            dst_i,
  input  logic                       bilinear_i,
  output logic [IdxW-1:0]            lo_o,
  output logic [IdxW-1:0]            hi_o,
  output logic [irs_pkg::FracW-1:0]  frac_o
);
  import irs_pkg::*;

  logic [DimW-1:0] rem_q [NumW];
  logic [NumW-1:0] num_q [NumW];
  logic [DimW-1:0] rem_d [NumW];
  logic [NumW-1:0] num_d [NumW];
  logic [NumW-1:0] num_in;

  logic [IdxW-1:0]  lo_q, hi_q, lo_d, hi_d;
  logic [FracW-1:0] frac_q, frac_d;

  always_comb begin
    if (bilinear_i == FilterBilinear) begin
      // (2d+1) * S * 128, the half-pixel-centred numerator.
      num_in = (NumW'({d_i, 1'b1}) * NumW'(src_i)) << 7;
    end else begin
      num_in = NumW'(d_i) * NumW'(src_i);
    end
  end

  // Each stage retires one quotient bit; the numerator shifts out as the
  // quotient shifts in.
  always_comb begin
    logic [DimW-1:0] srem;
    logic [NumW-1:0] snum;
    logic [DimW:0]   t;
    logic            ge;
    for (int i = 0; i < NumW; i++) begin
      srem = (i == 0) ? '0 : rem_q[(i == 0) ? 0 : i - 1];
      snum = (i == 0) ? num_in : num_q[(i == 0) ? 0 : i - 1];
      t = {srem, snum[NumW-1]};
      ge = (t >= {1'b0, dst_i});
      rem_d[i] = ge ? DimW'(t - {1'b0, dst_i}) : t[DimW-1:0];
      num_d[i] = {snum[NumW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumW; i++) begin
      if (en_i[i]) begin
        rem_q[i] <= rem_d[i];
        num_q[i] <= num_d[i];
      end
    end
  end

  always_comb begin
    logic [NumW-1:0] q;
    logic [DimW-1:0] smax;
    logic [NumW-1:0] c;
    logic [NumW-1:0] top;
    q = num_q[NumW-1];
    smax = src_i - DimW'(1);
    top = NumW'(smax) << FracW;
    c = '0;
    if (bilinear_i == FilterBilinear) begin
      c = (q < NumW'(128)) ? '0 : q - NumW'(128);
      if (c > top) begin
        c = top;
      end
      lo_d = IdxW'(c >> FracW);
      frac_d = c[FracW-1:0];
      hi_d = (lo_d == IdxW'(smax)) ? lo_d : lo_d + IdxW'(1);
    end else begin
      lo_d = (q > NumW'(smax)) ? IdxW'(smax) : IdxW'(q);
      hi_d = lo_d;
      frac_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[NumW]) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
      frac_q <= frac_d;
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;
  assign frac_o = frac_q;

endmodule

>>> rtl/irs_blend.sv
// ----------------------------------------------------------------------------
// irs_blend
// One channel lane: horizontal blend of two rows, then vertical blend into
// a 24-bit accumulator.
// ----------------------------------------------------------------------------
module irs_blend (
  input  logic                      clk_i,
  input  logic                      en_a_i,
  input  logic                      en_b_i,
  input  logic [irs_pkg::ChanW-1:0] p00_i,
  input  logic [irs_pkg::ChanW-1:0] p10_i,
  input  logic [irs_pkg::ChanW-1:0] p01_i,
  input  logic [irs_pkg::ChanW-1:0] p11_i,
  input  logic [irs_pkg::FracW-1:0] fx_i,
  input  logic [irs_pkg::FracW-1:0] fy_i,
  output logic [irs_pkg::AccW-1:0]  acc_o
);
  import irs_pkg::*;

  logic [15:0]      top_q, bot_q;
  logic [FracW-1:0] fy_q;
  logic [AccW-1:0]  acc_q;
  logic [8:0]       wx, wy;
  logic [16:0]      top_d, bot_d;
  logic [25:0]      acc_d;

  assign wx = 9'd256 - 9'(fx_i);
  assign wy = 9'd256 - 9'(fy_q);
  assign top_d = 17'(p00_i) * 17'(wx) + 17'(p10_i) * 17'(fx_i);
  assign bot_d = 17'(p01_i) * 17'(wx) + 17'(p11_i) * 17'(fx_i);
  assign acc_d = 26'(top_q) * 26'(wy) + 26'(bot_q) * 26'(fy_q);

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      top_q <= top_d[15:0];
      bot_q <= bot_d[15:0];
      fy_q <= fy_i;
    end
    if (en_b_i) begin
      acc_q <= acc_d[AccW-1:0];
    end
  end

  assign acc_o = acc_q;

endmodule

>>> rtl/image_resize_nearest_bilinear_core.sv
// ----------------------------------------------------------------------------
// image_resize_nearest_bilinear_core
// Nearest and bilinear image scaler with a banked source frame store.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while out_stall_i is low, set by the
// one-bit-per-stage coordinate dividers and the four parity banks that
// serve all bilinear taps at once. A store word gives no result.
// Reset clears the pipeline valid bits and the configuration registers to
// their defaults; the frame store is not cleared and holds nothing defined
// until written.
module image_resize_nearest_bilinear_core #(
  parameter int MAX_DIM = 128,
  parameter int NUM_CHANNELS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [irs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [irs_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic [irs_pkg::CoordW-1:0]  col_i,
  input  logic [irs_pkg::CoordW-1:0]  row_i,
  input  logic [irs_pkg::ChanW-1:0]   in_ch0_i,
  input  logic [irs_pkg::ChanW-1:0]   in_ch1_i,
  input  logic [irs_pkg::ChanW-1:0]   in_ch2_i,
  input  logic [irs_pkg::ChanW-1:0]   in_ch3_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [irs_pkg::ChanW-1:0]   out_ch0_o,
  output logic [irs_pkg::ChanW-1:0]   out_ch1_o,
  output logic [irs_pkg::ChanW-1:0]   out_ch2_o,
  output logic [irs_pkg::ChanW-1:0]   out_ch3_o
);
  import irs_pkg::*;

  localparam int DimW = $clog2(MAX_DIM + 1);
  localparam int IdxW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int NumW = CoordW + DimW + 8;
  localparam int Half = (MAX_DIM + 1) / 2;
  localparam int BankDepth = Half * Half;
  localparam int BankAW = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam int SlotCrd = NumW + 1;
  localparam int SlotRam = NumW + 2;
  localparam int SlotOut = NumW + 5;
  localparam int NumSlots = NumW + 6;

  // Configuration registers.
  logic [CfgW-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic            filter_q;
  logic [2:0]      nch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= CfgW'(1);
      src_h_q <= CfgW'(1);
      dst_w_q <= CfgW'(1);
      dst_h_q <= CfgW'(1);
      filter_q <= FilterNearest;
      nch_q <= 3'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSrcWidth:  src_w_q <= cfg_wdata_i;
        CfgSrcHeight: src_h_q <= cfg_wdata_i;
        CfgDstWidth:  dst_w_q <= cfg_wdata_i;
        CfgDstHeight: dst_h_q <= cfg_wdata_i;
        CfgFilter:    filter_q <= cfg_wdata_i[0];
        CfgChannels:  nch_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  function automatic logic [DimW-1:0] clamp_dim(input logic [CfgW-1:0] v);
    if (v == '0) begin
      return DimW'(1);
    end else if (32'(v) > MAX_DIM) begin
      return DimW'(MAX_DIM);
    end
    return DimW'(v);
  endfunction

  logic [DimW-1:0] sw, sh, dw, dh;
  int unsigned     nch;

  assign sw = clamp_dim(src_w_q);
  assign sh = clamp_dim(src_h_q);
  assign dw = clamp_dim(dst_w_q);
  assign dh = clamp_dim(dst_h_q);

  always_comb begin
    nch = 32'(nch_q);
    if (nch < 1) begin
      nch = 1;
    end
    if (nch > NUM_CHANNELS) begin
      nch = NUM_CHANNELS;
    end
  end

  // Pipeline control: a slot loads when it is empty or its word moves on.
  logic [NumSlots-1:0] v_q;
  logic [NumSlots:0]   en;
  item_t               pl_q [SlotCrd+1];
  item_t               in_item;

  always_comb begin
    en[NumSlots] = !out_stall_i;
    for (int p = NumSlots - 1; p >= 0; p--) begin
      en[p] = !v_q[p] || en[p+1];
    end
  end

  assign in_stall_o = !en[0];
  assign in_item = '{store: (action_i == ActStore), col: col_i, row: row_i,
                     pix: {in_ch3_i, in_ch2_i, in_ch1_i, in_ch0_i}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int p = 0; p < NumSlots; p++) begin
        if (en[p]) begin
          if (p == 0) begin
            v_q[p] <= in_valid_i;
          end else if (p == SlotRam) begin
            // Store words leave the pipeline once written.
            v_q[p] <= v_q[p-1] && !pl_q[SlotCrd].store;
          end else begin
            v_q[p] <= v_q[(p == 0) ? 0 : p - 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p <= SlotCrd; p++) begin
      if (en[p]) begin
        pl_q[p] <= (p == 0) ? in_item : pl_q[(p == 0) ? 0 : p - 1];
      end
    end
  end

  // Axis lanes.
  logic [IdxW-1:0]  x_lo, x_hi, y_lo, y_hi;
  logic [FracW-1:0] x_frac, y_frac;

  irs_coord #(.MAX_DIM(MAX_DIM)) u_coord_x (
    .clk_i      (clk_i),
    .en_i       (en[SlotCrd:1]),
    .d_i        (pl_q[0].col),
    .src_i      (sw),
    .dst_i      (dw),
    .bilinear_i (filter_q),
    .lo_o       (x_lo),
    .hi_o       (x_hi),
    .frac_o     (x_frac)
  );

  irs_coord #(.MAX_DIM(MAX_DIM)) u_coord_y (
    .clk_i      (clk_i),
    .en_i       (en[SlotCrd:1]),
    .d_i        (pl_q[0].row),
    .src_i      (sh),
    .dst_i      (dh),
    .bilinear_i (filter_q),
    .lo_o       (y_lo),
    .hi_o       (y_hi),
    .frac_o     (y_frac)
  );

  // Frame store in four banks by column and row parity, so the four taps of
  // a bilinear word always fall into different banks or coincide.
  logic [BankAW-1:0] raddr [4];
  logic [BankAW-1:0] waddr;
  logic [3:0]        we;
  logic [PixW-1:0]   rd [4];
  logic              wr_ok;
  item_t             crd;

  assign crd = pl_q[SlotCrd];
  assign wr_ok = (32'(crd.col) < MAX_DIM) && (32'(crd.row) < MAX_DIM);
  assign waddr = BankAW'(32'(crd.row >> 1) * Half + 32'(crd.col >> 1));

  always_comb begin
    logic [IdxW-1:0] xs, ys;
    for (int b = 0; b < 4; b++) begin
      xs = (x_lo[0] == b[0]) ? x_lo : x_hi;
      ys = (y_lo[0] == b[1]) ? y_lo : y_hi;
      raddr[b] = BankAW'(32'(ys >> 1) * Half + 32'(xs >> 1));
      we[b] = en[SlotRam] && v_q[SlotCrd] && crd.store && wr_ok
              && ({crd.row[0], crd.col[0]} == 2'(b));
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    irs_ram #(.Width(PixW), .Depth(BankDepth)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[b]),
      .waddr_i (waddr),
      .wdata_i (crd.pix),
      .re_i    (en[SlotRam]),
      .raddr_i (raddr[b]),
      .rdata_o (rd[b])
    );
  end

  logic [FracW-1:0] fx_q, fy_q;
  logic [1:0]       b00_q, b10_q, b01_q, b11_q;

  always_ff @(posedge clk_i) begin
    if (en[SlotRam]) begin
      fx_q <= x_frac;
      fy_q <= y_frac;
      b00_q <= {y_lo[0], x_lo[0]};
      b10_q <= {y_lo[0], x_hi[0]};
      b01_q <= {y_hi[0], x_lo[0]};
      b11_q <= {y_hi[0], x_hi[0]};
    end
  end

  // Channel lanes and the merging output stage.
  logic [AccW-1:0]  acc [4];
  logic [ChanW-1:0] out_q [4];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    if (k < NUM_CHANNELS) begin : g_on
      irs_blend u_blend (
        .clk_i  (clk_i),
        .en_a_i (en[SlotRam+1]),
        .en_b_i (en[SlotRam+2]),
        .p00_i  (rd[b00_q][ChanW*k +: ChanW]),
        .p10_i  (rd[b10_q][ChanW*k +: ChanW]),
        .p01_i  (rd[b01_q][ChanW*k +: ChanW]),
        .p11_i  (rd[b11_q][ChanW*k +: ChanW]),
        .fx_i   (fx_q),
        .fy_i   (fy_q),
        .acc_o  (acc[k])
      );
    end else begin : g_off
      assign acc[k] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [AccW:0] r;
    if (en[SlotOut]) begin
      for (int k = 0; k < 4; k++) begin
        r = ((AccW + 1)'(acc[k]) + (AccW + 1)'(32768)) >> 16;
        if (k >= nch) begin
          out_q[k] <= '0;
        end else if (r > (AccW + 1)'(255)) begin
          out_q[k] <= 8'hFF;
        end else begin
          out_q[k] <= r[ChanW-1:0];
        end
      end
    end
  end

  assign out_valid_o = v_q[SlotOut];
  assign out_ch0_o = out_q[0];
  assign out_ch1_o = out_q[1];
  assign out_ch2_o = out_q[2];
  assign out_ch3_o = out_q[3];

endmodule

>>> rtl/irs_checker.sv
// ----------------------------------------------------------------------------
// irs_checker
// Port-level checks of the image scaler, bound to the top level.
// ----------------------------------------------------------------------------
module irs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic [irs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input logic [irs_pkg::CfgW-1:0]    cfg_wdata_i,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        action_i,
  input logic [irs_pkg::CoordW-1:0]  col_i,
  input logic [irs_pkg::CoordW-1:0]  row_i,
  input logic [irs_pkg::ChanW-1:0]   in_ch0_i,
  input logic [irs_pkg::ChanW-1:0]   in_ch1_i,
  input logic [irs_pkg::ChanW-1:0]   in_ch2_i,
  input logic [irs_pkg::ChanW-1:0]   in_ch3_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [irs_pkg::ChanW-1:0]   out_ch0_o,
  input logic [irs_pkg::ChanW-1:0]   out_ch1_o,
  input logic [irs_pkg::ChanW-1:0]   out_ch2_o,
  input logic [irs_pkg::ChanW-1:0]   out_ch3_o
);

  // The input only backs up when the whole pipeline is full behind a
  // stalled result.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(out_ch0_o) && $stable(out_ch1_o)
      && $stable(out_ch2_o) && $stable(out_ch3_o)))
    else $error("stalled result changed");

endmodule

bind image_resize_nearest_bilinear_core irs_checker u_checker (.*);

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the image scaler. A directed stimulus table covers
// reset defaults, register saturation, channel masking and both filters.
// Random phases then follow with many frame and scale settings. Every accepted
// compute word is predicted in the bench and compared, channel by channel,
// with the block's output. Both sides idle and stall at random until phase 8.
// ----------------------------------------------------------------------------
module tb_top;
  import irs_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpare7 = 3'd7;
  localparam int FrameDim = 128;
  localparam int DrainCycles = 40;
  localparam int CycleLimit = 600000;

  typedef enum logic {RowCfg, RowWord} row_kind_e;
  typedef struct {
    row_kind_e         kind;
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]   val;
    logic              act;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [PixW-1:0]   pix;
    bit                typed;
    logic [PixW-1:0]   want;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  logic               action = 1'b0;
  logic [CoordW-1:0]  col = '0;
  logic [CoordW-1:0]  row = '0;
  logic [ChanW-1:0]   in_ch0 = '0, in_ch1 = '0, in_ch2 = '0, in_ch3 = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b1;
  logic [ChanW-1:0]   out_ch0_o, out_ch1_o, out_ch2_o, out_ch3_o;

  image_resize_nearest_bilinear_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall_o),
    .action_i(action), .col_i(col), .row_i(row),
    .in_ch0_i(in_ch0), .in_ch1_i(in_ch1), .in_ch2_i(in_ch2), .in_ch3_i(in_ch3),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall),
    .out_ch0_o(out_ch0_o), .out_ch1_o(out_ch1_o),
    .out_ch2_o(out_ch2_o), .out_ch3_o(out_ch3_o)
  );

  // Bench copy of the registers and of the frame store.
  logic [7:0]      src_w_reg = 8'd1, src_h_reg = 8'd1, dst_w_reg = 8'd1, dst_h_reg = 8'd1;
  logic            filter_reg = FilterNearest;
  logic [2:0]      chan_reg = 3'd4;
  logic [PixW-1:0] frame_mem [FrameDim*FrameDim];
  bit              frame_set [FrameDim*FrameDim];

  logic [PixW-1:0] pixel_q [$];
  dir_row_t        dir_rows [$];
  int  mismatches = 0;
  int  send_idle = 9;
  int  recv_idle = 45;
  int  hold_len = 0;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_cnt = 0;
  longint cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int clamp_size(logic [7:0] v);
    if (v == 0) return 1;
    if (v > FrameDim) return FrameDim;
    return int'(v);
  endfunction

  function automatic int near_idx(int d, int s, int dd);
    int q;
    q = (d * s) / dd;
    return (q > s - 1) ? s - 1 : q;
  endfunction

  function automatic int blin_coord(int d, int s, int dd);
    int q;
    q = ((2 * d + 1) * s * 128) / dd;
    if (q < 128) return 0;
    q = q - 128;
    return (q > (s - 1) * 256) ? (s - 1) * 256 : q;
  endfunction

  function automatic logic [PixW-1:0] scaled_pixel(int c, int r);
    int sw, sh, dw, dh, nch, cx, cy, x0, y0, x1, y1, fx, fy;
    int top, bot, acc, v;
    logic [PixW-1:0] p00, p10, p01, p11, res;
    sw = clamp_size(src_w_reg);
    sh = clamp_size(src_h_reg);
    dw = clamp_size(dst_w_reg);
    dh = clamp_size(dst_h_reg);
    nch = (chan_reg == 0) ? 1 : (chan_reg > 4) ? 4 : int'(chan_reg);
    res = '0;
    if (filter_reg == FilterNearest) begin
      p00 = frame_mem[near_idx(r, sh, dh) * FrameDim + near_idx(c, sw, dw)];
      for (int k = 0; k < nch; k++) res[8*k +: 8] = p00[8*k +: 8];
    end else begin
      cx = blin_coord(c, sw, dw);
      cy = blin_coord(r, sh, dh);
      x0 = cx >> 8;
      y0 = cy >> 8;
      fx = cx & 255;
      fy = cy & 255;
      x1 = (x0 + 1 > sw - 1) ? sw - 1 : x0 + 1;
      y1 = (y0 + 1 > sh - 1) ? sh - 1 : y0 + 1;
      p00 = frame_mem[y0 * FrameDim + x0];
      p10 = frame_mem[y0 * FrameDim + x1];
      p01 = frame_mem[y1 * FrameDim + x0];
      p11 = frame_mem[y1 * FrameDim + x1];
      for (int k = 0; k < nch; k++) begin
        top = p00[8*k +: 8] * (256 - fx) + p10[8*k +: 8] * fx;
        bot = p01[8*k +: 8] * (256 - fx) + p11[8*k +: 8] * fx;
        acc = top * (256 - fy) + bot * fy;
        v = (acc + 32768) >> 16;
        res[8*k +: 8] = (v > 255) ? 8'd255 : v[7:0];
      end
    end
    return res;
  endfunction

  // Caller lowers cfg_we after its last write.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (idx)
      CfgSrcWidth:  src_w_reg = val;
      CfgSrcHeight: src_h_reg = val;
      CfgDstWidth:  dst_w_reg = val;
      CfgDstHeight: dst_h_reg = val;
      CfgFilter:    filter_reg = val[0];
      CfgChannels:  chan_reg = val[2:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Offers one word and updates the prediction when it is accepted.
  task automatic send_word(logic act, int c, int r, logic [PixW-1:0] pix,
                           bit typed = 0, logic [PixW-1:0] want = '0);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action <= act;
    col <= CoordW'(c);
    row <= CoordW'(r);
    {in_ch3, in_ch2, in_ch1, in_ch0} <= pix;
    do @(posedge clk_i); while (in_stall_o);
    if (act == ActStore) begin
      frame_mem[r * FrameDim + c] = pix;
      frame_set[r * FrameDim + c] = 1;
    end else begin
      pixel_q.push_back(typed ? want : scaled_pixel(c, r));
    end
  endtask

  always @(posedge clk_i) begin
    logic [PixW-1:0] got, exp_pix;
    if (rst_ni && out_valid_o && !out_stall) begin
      got = {out_ch3_o, out_ch2_o, out_ch1_o, out_ch0_o};
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output pixel %h", got);
      end else begin
        exp_pix = pixel_q.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (got[8*k +: 8] !== exp_pix[8*k +: 8]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("channel %0d: expected %h, got %h", k, exp_pix[8*k +: 8],
                       got[8*k +: 8]);
          end
        end
      end
    end
    if (hold_req != hold_seen) begin
      hold_cnt = hold_len;
      hold_seen = hold_req;
    end
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  function automatic void dcfg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    dir_row_t r;
    r = '{RowCfg, idx, val, 1'b0, '0, '0, '0, 0, '0};
    dir_rows.push_back(r);
  endfunction

  function automatic void dword(logic act, int c, int r, logic [PixW-1:0] pix,
                                bit typed = 0, logic [PixW-1:0] want = '0);
    dir_row_t d;
    d = '{RowWord, '0, '0, act, CoordW'(c), CoordW'(r), pix, typed, want};
    dir_rows.push_back(d);
  endfunction

  initial begin
    int sw, sh, dw, dh, n;
    logic [7:0] swv, shv, dwv, dhv;
    bit in_cfg;

    // Directed table. Expected pixels are typed in where they are obvious.
    dword(ActStore, 0, 0, 32'h44332211);
    dword(ActCompute, 0, 0, '0, 1, 32'h44332211);
    dword(ActCompute, 127, 127, '0, 1, 32'h44332211);
    dword(ActStore, 127, 127, 32'hFFFFFFFF);
    dword(ActStore, 127, 0, 32'h00000000);
    dcfg(CfgChannels, 8'd0);
    dword(ActCompute, 0, 0, '0, 1, 32'h00000011);
    dcfg(CfgChannels, 8'd7);
    dcfg(CfgFilter, CfgW'(FilterBilinear));
    dword(ActCompute, 64, 3, '0, 1, 32'h44332211);
    dcfg(CfgSpare6, 8'hFF);
    dcfg(CfgSpare7, 8'h55);
    dcfg(CfgSrcWidth, 8'd0);
    dcfg(CfgDstWidth, 8'd0);
    dword(ActCompute, 1, 1, '0, 1, 32'h44332211);
    dcfg(CfgSrcWidth, 8'd2);
    dcfg(CfgSrcHeight, 8'd2);
    dcfg(CfgDstWidth, 8'd3);
    dcfg(CfgDstHeight, 8'd3);
    dword(ActStore, 1, 0, 32'hFFFFFFFF);
    dword(ActStore, 0, 1, 32'h00000000);
    dword(ActStore, 1, 1, 32'h80FF00FF);
    dword(ActCompute, 0, 0, '0);
    dword(ActCompute, 1, 1, '0);
    dword(ActCompute, 2, 2, '0);
    dcfg(CfgFilter, CfgW'(FilterNearest));
    dword(ActCompute, 2, 1, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_cfg = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowCfg) begin
        if (!in_cfg) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        write_reg(dir_rows[i].idx, dir_rows[i].val);
        in_cfg = 1;
      end else begin
        if (in_cfg) cfg_we <= 1'b0;
        in_cfg = 0;
        send_word(dir_rows[i].act, dir_rows[i].col, dir_rows[i].row, dir_rows[i].pix,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases, each with its own frame and scale setting.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle = 45;
        recv_idle = 9;
      end else if (ph == 8) begin
        send_idle = 0;
        recv_idle = 0;
      end
      in_valid <= 1'b0;
      wait_drained();
      swv = 8'($urandom_range(1, 9));
      shv = 8'($urandom_range(1, 9));
      dwv = 8'($urandom_range(1, 12));
      dhv = 8'($urandom_range(1, 12));
      case (ph)
        1: begin swv = 8'hFF; shv = 8'd1; end
        3: begin swv = 8'd2; shv = 8'd128; dwv = 8'd1; dhv = 8'hFF; end
        6: begin dwv = 8'd128; dhv = 8'd128; end
        9: begin swv = 8'd0; shv = 8'd0; dwv = 8'd0; dhv = 8'd1; end
        default: ;
      endcase
      write_reg(CfgSrcWidth, swv);
      write_reg(CfgSrcHeight, shv);
      write_reg(CfgDstWidth, dwv);
      write_reg(CfgDstHeight, dhv);
      write_reg(CfgFilter, CfgW'(ph[0] ? FilterBilinear : FilterNearest));
      write_reg(CfgChannels, CfgW'($urandom_range(0, 7)));
      cfg_we <= 1'b0;
      sw = clamp_size(swv);
      sh = clamp_size(shv);
      dw = clamp_size(dwv);
      dh = clamp_size(dhv);

      // Every pixel a compute can read must hold a written value.
      for (int y = 0; y < sh; y++)
        for (int x = 0; x < sw; x++)
          if (!frame_set[y * FrameDim + x]) send_word(ActStore, x, y, $urandom);

      if (ph == 2) begin
        hold_len = 300;
        hold_req++;
      end
      n = (ph == 6) ? 100 : 120;
      for (int i = 0; i < n; i++) begin
        if (ph == 5 && i == 60) begin
          in_valid <= 1'b0;
          while (pixel_q.size() != 0) @(posedge clk_i);
        end
        if ($urandom_range(99) < 60) begin
          if ($urandom_range(99) < 80)
            send_word(ActCompute, $urandom_range(dw - 1), $urandom_range(dh - 1), $urandom);
          else
            send_word(ActCompute, $urandom_range(127), $urandom_range(127), $urandom);
        end else begin
          if ($urandom_range(99) < 80)
            send_word(ActStore, $urandom_range(sw - 1), $urandom_range(sh - 1), $urandom);
          else
            send_word(ActStore, $urandom_range(127), $urandom_range(127), $urandom);
        end
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
